// ===== rtl/core/lpd_pkg.sv =====
// Shared types and constants for the length-prefixed deframer with UTF-8 check.
// Used by the channel interfaces, the deframer, the UTF-8 checker and the top level.
// Depends on nothing.
package lpd_pkg;

   // Field widths of the byte stream and of the length prefix.
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned LENGTH_W  = 32;
   localparam int unsigned STATUS_W  = 2;
   localparam int unsigned CONT_W    = 2;
   localparam int unsigned PREFIX_W  = 2;

   // Reset value of the maximum payload length register.
   localparam logic [LENGTH_W-1:0] MAX_LENGTH_RESET = 32'd65536;

   // Frame status codes reported with the final beat of a frame.
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_UTF8  = 2'd2;

   // Index of the last prefix byte.
   localparam logic [PREFIX_W-1:0] PREFIX_LAST = 2'd3;

   // UTF-8 lead and continuation byte tags.
   localparam logic [1:0] UTF8_CONT_TAG  = 2'b10;
   localparam logic [2:0] UTF8_LEAD2_TAG = 3'b110;
   localparam logic [3:0] UTF8_LEAD3_TAG = 4'b1110;
   localparam logic [4:0] UTF8_LEAD4_TAG = 5'b11110;

   // Continuation counts owed after each kind of lead byte.
   localparam logic [CONT_W-1:0] CONT_NONE  = 2'd0;
   localparam logic [CONT_W-1:0] CONT_LEAD2 = 2'd1;
   localparam logic [CONT_W-1:0] CONT_LEAD3 = 2'd2;
   localparam logic [CONT_W-1:0] CONT_LEAD4 = 2'd3;

   // One result beat.
   typedef struct packed {
      logic [BYTE_W-1:0]   payload_byte;
      logic                frame_end;
      logic                empty_frame;
      logic [STATUS_W-1:0] frame_status;
      logic [LENGTH_W-1:0] frame_length;
   } rsp_type;

   // UTF-8 checker state carried between bytes.
   typedef struct packed {
      logic [CONT_W-1:0] cont_due;
      logic              error_seen;
   } utf8_state_type;

endpackage

// ===== rtl/core/lpd_channels.sv =====
// Valid/ready channel interfaces for the deframer: received bytes in, result beats out.
// Depends on lpd_pkg for field widths.

interface lpd_req_if;
   logic                        valid;
   logic                        ready;
   logic [lpd_pkg::BYTE_W-1:0]  rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lpd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [lpd_pkg::BYTE_W-1:0]    payload_byte;
   logic                          frame_end;
   logic                          empty_frame;
   logic [lpd_pkg::STATUS_W-1:0]  frame_status;
   logic [lpd_pkg::LENGTH_W-1:0]  frame_length;

   modport source (output valid, output payload_byte, output frame_end, output empty_frame,
                   output frame_status, output frame_length, input ready);
   modport sink   (input valid, input payload_byte, input frame_end, input empty_frame,
                   input frame_status, input frame_length, output ready);
endinterface

// ===== rtl/core/lpd_utf8_check.sv =====
// Next-state logic of the loose UTF-8 check for one payload byte.
// Depends on lpd_pkg for the tags and the checker state type.
module lpd_utf8_check (
   input  logic [lpd_pkg::BYTE_W-1:0] data_byte,
   input  lpd_pkg::utf8_state_type    state_cur,
   output lpd_pkg::utf8_state_type    state_next
);

   // Continuations are only checked for their tag; lead bytes set the count owed.
   // Overlong two-byte leads and bytes that cannot start a sequence are errors.
   always_comb begin
      state_next = state_cur;
      if (state_cur.cont_due != lpd_pkg::CONT_NONE) begin
         if (data_byte[7:6] != lpd_pkg::UTF8_CONT_TAG) begin
            state_next.error_seen = 1'b1;
         end
         state_next.cont_due = state_cur.cont_due - 2'd1;
      end else if (data_byte[7] == 1'b0) begin
         state_next.cont_due = lpd_pkg::CONT_NONE;
      end else if (data_byte[7:5] == lpd_pkg::UTF8_LEAD2_TAG) begin
         state_next.cont_due = lpd_pkg::CONT_LEAD2;
         if (data_byte[4:1] == 4'd0) begin
            state_next.error_seen = 1'b1;
         end
      end else if (data_byte[7:4] == lpd_pkg::UTF8_LEAD3_TAG) begin
         state_next.cont_due = lpd_pkg::CONT_LEAD3;
      end else if (data_byte[7:3] == lpd_pkg::UTF8_LEAD4_TAG) begin
         state_next.cont_due = lpd_pkg::CONT_LEAD4;
      end else begin
         state_next.error_seen = 1'b1;
      end
   end

endmodule

// ===== rtl/core/lpd_deframer.sv =====
// Framing state machine: gathers the length prefix, counts payload bytes and forms results.
// Depends on lpd_pkg and lpd_utf8_check.
module lpd_deframer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic [lpd_pkg::BYTE_W-1:0]   data_byte,
   input  logic [lpd_pkg::LENGTH_W-1:0] max_length,
   output logic                         result_valid,
   output lpd_pkg::rsp_type             result
);

   typedef enum logic [1:0] {
      PH_PREFIX,
      PH_PAYLOAD,
      PH_HALT
   } phase_type;

   phase_type                     phase_ff, phase_in;
   logic [lpd_pkg::PREFIX_W-1:0]  prefix_count_ff, prefix_count_in;
   logic [lpd_pkg::LENGTH_W-1:0]  length_ff, length_in;
   logic [lpd_pkg::LENGTH_W-1:0]  bytes_left_ff, bytes_left_in;
   lpd_pkg::utf8_state_type       utf8_ff, utf8_in, utf8_fed;
   logic [lpd_pkg::LENGTH_W-1:0]  shifted_length;
   logic                          last_byte;

   lpd_utf8_check u_utf8 (
      .data_byte  (data_byte),
      .state_cur  (utf8_ff),
      .state_next (utf8_fed)
   );

   assign shifted_length = {length_ff[lpd_pkg::LENGTH_W-lpd_pkg::BYTE_W-1:0], data_byte};
   assign last_byte      = (bytes_left_ff <= 32'd1);

   // Per-byte decisions; state moves only when the byte is stepped through.
   always_comb begin
      phase_in        = phase_ff;
      prefix_count_in = prefix_count_ff;
      length_in       = length_ff;
      bytes_left_in   = bytes_left_ff;
      utf8_in         = utf8_ff;
      result_valid    = 1'b0;
      result          = '{payload_byte: '0, frame_end: 1'b0, empty_frame: 1'b0,
                          frame_status: lpd_pkg::STATUS_OK, frame_length: length_ff};
      unique case (phase_ff)
         PH_PREFIX: begin
            length_in       = shifted_length;
            prefix_count_in = prefix_count_ff + 2'd1;
            result.frame_length = shifted_length;
            if (prefix_count_ff == lpd_pkg::PREFIX_LAST) begin
               if (shifted_length > max_length) begin
                  result_valid        = 1'b1;
                  result.frame_end    = 1'b1;
                  result.frame_status = lpd_pkg::STATUS_TOO_LARGE;
                  phase_in            = PH_HALT;
               end else if (shifted_length == '0) begin
                  result_valid       = 1'b1;
                  result.frame_end   = 1'b1;
                  result.empty_frame = 1'b1;
               end else begin
                  phase_in      = PH_PAYLOAD;
                  bytes_left_in = shifted_length;
                  utf8_in       = '0;
               end
            end
         end
         PH_PAYLOAD: begin
            result_valid        = 1'b1;
            result.payload_byte = data_byte;
            if (last_byte) begin
               result.frame_end = 1'b1;
               if (utf8_fed.error_seen || (utf8_fed.cont_due != lpd_pkg::CONT_NONE)) begin
                  result.frame_status = lpd_pkg::STATUS_BAD_UTF8;
               end
               phase_in        = PH_PREFIX;
               prefix_count_in = '0;
               bytes_left_in   = '0;
               utf8_in         = '0;
            end else begin
               bytes_left_in = bytes_left_ff - 32'd1;
               utf8_in       = utf8_fed;
            end
         end
         default: begin
            // Framing is lost: every byte is dropped until reset.
            phase_in = PH_HALT;
         end
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_PREFIX;
         prefix_count_ff <= '0;
         length_ff       <= '0;
         bytes_left_ff   <= '0;
         utf8_ff         <= '0;
      end else if (step) begin
         phase_ff        <= phase_in;
         prefix_count_ff <= prefix_count_in;
         length_ff       <= length_in;
         bytes_left_ff   <= bytes_left_in;
         utf8_ff         <= utf8_in;
      end
   end

endmodule

// ===== rtl/core/length_prefix_deframer_utf8_check.sv =====
// Top level of the length-prefixed deframer with loose UTF-8 check.
// Depends on lpd_pkg, the channel interfaces in lpd_channels and lpd_deframer.
//
// Usage:
//   Received bytes enter on the req channel, one byte per beat. Each frame is a
//   4-byte big-endian length followed by that many payload bytes. Every payload
//   byte leaves on the rsp channel, the last one marked with frame_end and the
//   frame status. An empty frame gives one beat at its fourth prefix byte; a
//   length above the csr maximum gives one beat with the too-large status, after
//   which all bytes are dropped until reset.
//   An accepted byte is held in the input register, passes through the framing
//   logic, and any result it gives is stored in the result register. Throughput is
//   one byte per cycle while the receiver does not stall, set by the single pass
//   from the input register through the framing logic to the result register.
//   The csr maximum (reset 65536) is written with csr_write_enable and is checked
//   against each length as its last prefix byte is processed. Reset is synchronous
//   and clears the framing state and both registers' valid flags. When the receiver
//   stalls, the result register holds its beat, one more byte waits in the input
//   register, and then req ready falls until the result is taken.
module length_prefix_deframer_utf8_check (
   input  logic                          clock,
   input  logic                          reset,
   lpd_req_if.sink                       req_if,
   lpd_rsp_if.source                     rsp_if,
   input  logic                          csr_write_enable,
   input  logic [lpd_pkg::LENGTH_W-1:0]  csr_write_data
);

   logic                          in_valid_ff, in_valid_in;
   logic [lpd_pkg::BYTE_W-1:0]    in_byte_ff, in_byte_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   lpd_pkg::rsp_type              rsp_ff, rsp_in;
   logic [lpd_pkg::LENGTH_W-1:0]  max_length_ff, max_length_in;
   logic                          req_take;
   logic                          advance;
   logic                          result_valid;
   lpd_pkg::rsp_type              result;

   // A held byte moves on whenever the result register is free or being emptied.
   assign advance       = in_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready  = !in_valid_ff || advance;
   assign req_take      = req_if.valid && req_if.ready;

   lpd_deframer u_deframer (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .data_byte    (in_byte_ff),
      .max_length   (max_length_ff),
      .result_valid (result_valid),
      .result       (result)
   );

   // Next values of the input register, result register and csr.
   always_comb begin
      in_valid_in   = in_valid_ff;
      in_byte_in    = in_byte_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      max_length_in = max_length_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_if.rx_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      if (advance && result_valid) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_write_enable) begin
         max_length_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         max_length_ff <= lpd_pkg::MAX_LENGTH_RESET;
      end else begin
         in_valid_ff   <= in_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         max_length_ff <= max_length_in;
      end
      in_byte_ff <= in_byte_in;
      rsp_ff     <= rsp_in;
   end

   // Result beat outputs.
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.payload_byte = rsp_ff.payload_byte;
   assign rsp_if.frame_end    = rsp_ff.frame_end;
   assign rsp_if.empty_frame  = rsp_ff.empty_frame;
   assign rsp_if.frame_status = rsp_ff.frame_status;
   assign rsp_if.frame_length = rsp_ff.frame_length;

endmodule
